// ===== hdl/ucmq_pkg.sv =====
// Package for the urgent-capable message queue block.
// Holds sizes, status codes and the command record passed front to back.
`default_nettype none
package ucmq_pkg;
  localparam int NUM_QUEUES = 4;
  localparam int DEPTH = 16;
  localparam int MSG_BYTES = 8;
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int SW = $clog2(DEPTH);
  localparam int AW = QW + SW;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_QUEUE   = 3'd1,
    ST_ZERO_LEN    = 3'd2,
    ST_NOT_CREATED = 3'd3,
    ST_TOO_BIG     = 3'd4,
    ST_EMPTY_FULL  = 3'd5,
    ST_WOULD_BLOCK = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_ACTIVE  = 2'd0,
    REG_CREATED = 2'd1,
    REG_NODES   = 2'd2,
    REG_MAXLEN  = 2'd3
  } reg_index_t;

  // One classified request, as queued between front and back.
  typedef struct packed {
    logic          is_write;
    logic          bad_queue;
    status_t       pre_status;
    logic [QW-1:0] queue;
    logic [63:0]   data;
    logic [3:0]    len;
    logic          urgent;
    logic          may_wait;
  } cmd_t;

  // Bytes below n kept, rest cleared.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    return m;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/ucmq_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module ucmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH_W = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH_W)-1:0] waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH_W)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);
  logic [WIDTH-1:0] mem [DEPTH_W];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/ucmq_front.sv =====
// Front end: holds configuration, checks queue index, length and creation.
// Depends on ucmq_pkg.
`default_nettype none
module ucmq_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_type,
  input  wire logic [2:0]               queue_id,
  input  wire logic [63:0]              write_data,
  input  wire logic [3:0]               byte_len,
  input  wire logic                     urgent,
  input  wire logic                     may_wait,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [4:0]               cfg_data,
  output ucmq_pkg::cmd_t                cmd,
  output logic [4:0]                    node_count,
  output logic [3:0]                    max_msg_bytes
);
  import ucmq_pkg::*;

  logic [2:0] active_queues;
  logic [3:0] created_mask;
  logic       bad;
  status_t    pre;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_queues <= 3'd4;
      created_mask  <= 4'd0;
      node_count    <= 5'd16;
      max_msg_bytes <= 4'd8;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ACTIVE:  active_queues <= cfg_data[2:0];
        REG_CREATED: created_mask  <= cfg_data[3:0];
        REG_NODES:   node_count    <= cfg_data;
        REG_MAXLEN:  max_msg_bytes <= cfg_data[3:0];
        default:     ;
      endcase
    end
  end

  // Checks that need no queue state.
  always_comb begin
    bad = (queue_id >= active_queues) || (32'(queue_id) >= NUM_QUEUES);
    pre = ST_OK;
    if (bad) begin
      pre = ST_BAD_QUEUE;
    end else if (byte_len == 4'd0) begin
      pre = ST_ZERO_LEN;
    end else if (queue_id >= 3'd4 || !created_mask[queue_id[1:0]]) begin
      pre = ST_NOT_CREATED;
    end
  end

  always_comb begin
    cmd.is_write   = req_type;
    cmd.bad_queue  = bad;
    cmd.pre_status = pre;
    cmd.queue      = queue_id[QW-1:0];
    cmd.data       = write_data;
    cmd.len        = byte_len;
    cmd.urgent     = urgent;
    cmd.may_wait   = may_wait;
  end
endmodule
`default_nettype wire

// ===== hdl/ucmq_fifo.sv =====
// Short command queue between the front and back parts.
// Depends on ucmq_pkg.
`default_nettype none
module ucmq_fifo (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  ucmq_pkg::cmd_t din,
  input  wire logic     pop,
  output ucmq_pkg::cmd_t dout,
  output logic          not_empty,
  output logic          full
);
  import ucmq_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  cmd_t           store [FIFO_DEPTH];
  logic [PW-1:0]  rd_ptr;
  logic [PW-1:0]  wr_ptr;
  logic [PW:0]    count;

  assign dout      = store[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == (PW+1)'(FIFO_DEPTH);

  // Pointer and count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ucmq_back.sv =====
// Back end: per-queue pointers, slot memories and the result register.
// Depends on ucmq_pkg and ucmq_ram.
`default_nettype none
module ucmq_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  ucmq_pkg::cmd_t     cmd,
  input  wire logic [4:0]    node_count,
  input  wire logic [3:0]    max_msg_bytes,
  output logic               cmd_pop,
  output logic               busy_back,
  output logic               done,
  output logic [2:0]         status,
  output logic [63:0]        read_data,
  output logic [3:0]         read_len,
  output logic [4:0]         peak_fill
);
  import ucmq_pkg::*;

  typedef enum logic { S_IDLE, S_READ } state_t;

  state_t         state;
  cmd_t           cur;
  logic [SW-1:0]  head_index [NUM_QUEUES];
  logic [SW-1:0]  tail_index [NUM_QUEUES];
  logic [FW-1:0]  fill_count [NUM_QUEUES];
  logic [FW-1:0]  peak_count [NUM_QUEUES];

  logic [FW-1:0]  nodes;
  logic [3:0]     limit;
  logic [SW-1:0]  h, t, new_head, slot;
  logic [FW-1:0]  f, pk;
  logic           ram_we;
  logic [AW-1:0]  waddr, raddr;
  logic [63:0]    pay_q;
  logic [3:0]     len_q;
  logic [3:0]     rlen;
  logic [3:0]     stored_len;
  logic           go_write;

  // Effective slot count and message limit.
  always_comb begin
    if (node_count == 5'd0) begin
      nodes = FW'(1);
    end else if (32'(node_count) > DEPTH) begin
      nodes = FW'(DEPTH);
    end else begin
      nodes = FW'(node_count);
    end
    limit = (32'(max_msg_bytes) < MSG_BYTES) ? max_msg_bytes : 4'(MSG_BYTES);
  end

  // Per-queue state of the command at the head of the queue.
  always_comb begin
    h  = head_index[cmd.queue];
    t  = tail_index[cmd.queue];
    f  = fill_count[cmd.queue];
    pk = peak_count[cmd.queue];
    // A head at zero or beyond a shrunken slot count restarts at the last slot.
    if (h == '0 || FW'(h) > nodes) begin
      new_head = SW'(nodes - 1'b1);
    end else begin
      new_head = h - 1'b1;
    end
    slot     = (cmd.is_write && cmd.urgent) ? new_head : (cmd.is_write ? t : h);
    go_write = cmd_valid && state == S_IDLE && cmd.pre_status == ST_OK
               && cmd.is_write && cmd.len <= limit && f < nodes;
    ram_we   = go_write;
    waddr    = {cmd.queue, slot};
    raddr    = {cmd.queue, h};
  end

  ucmq_ram #(.WIDTH(64), .DEPTH_W(NUM_QUEUES * DEPTH)) u_pay (
    .clk, .we(ram_we), .waddr(waddr), .wdata(cmd.data & byte_mask(cmd.len)),
    .raddr(raddr), .rdata(pay_q)
  );
  ucmq_ram #(.WIDTH(4), .DEPTH_W(NUM_QUEUES * DEPTH)) u_len (
    .clk, .we(ram_we), .waddr(waddr), .wdata(cmd.len),
    .raddr(raddr), .rdata(len_q)
  );

  assign stored_len = len_q;
  assign rlen = (cur.len < stored_len) ? cur.len : stored_len;
  assign cmd_pop   = cmd_valid && state == S_IDLE;
  assign busy_back = state != S_IDLE;

  // Sequencer: a successful read waits in S_READ for the registered slot memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_index[i] <= '0;
        tail_index[i] <= '0;
        fill_count[i] <= '0;
        peak_count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur       <= cmd;
            read_data <= '0;
            read_len  <= '0;
            peak_fill <= cmd.bad_queue ? '0 : 5'(pk);
            if (cmd.pre_status != ST_OK) begin
              status <= cmd.pre_status;
              done   <= 1'b1;
            end else if (cmd.is_write) begin
              done <= 1'b1;
              if (cmd.len > limit) begin
                status <= ST_TOO_BIG;
              end else if (f >= nodes) begin
                status <= cmd.may_wait ? ST_WOULD_BLOCK : ST_EMPTY_FULL;
              end else begin
                status <= ST_OK;
                if (cmd.urgent) begin
                  head_index[cmd.queue] <= new_head;
                end else begin
                  tail_index[cmd.queue] <= (FW'(t) + 1'b1 >= nodes) ? '0 : t + 1'b1;
                end
                fill_count[cmd.queue] <= f + 1'b1;
                if (f + 1'b1 > pk) begin
                  peak_count[cmd.queue] <= f + 1'b1;
                  peak_fill <= 5'(f + 1'b1);
                end
              end
            end else if (f == '0) begin
              status <= cmd.may_wait ? ST_WOULD_BLOCK : ST_EMPTY_FULL;
              done   <= 1'b1;
            end else begin
              status <= ST_OK;
              head_index[cmd.queue] <= (FW'(h) + 1'b1 >= nodes) ? '0 : h + 1'b1;
              fill_count[cmd.queue] <= f - 1'b1;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          read_len  <= rlen;
          read_data <= pay_q & byte_mask(rlen);
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/urgent_capable_message_queue.sv =====
// Top level of the urgent-capable message queue block.
// Depends on ucmq_pkg, ucmq_front, ucmq_fifo and ucmq_back.
//
// Usage: a request is taken at a clock edge with start high and busy low.
// The front part checks the queue index, length and created bit and puts
// the request into a two-entry command queue. The back part reads the
// queue's pointers, updates them and the slot memory, and shows one result
// for one cycle with done high: status, read_data, read_len, peak_fill.
// A write or failed request gives its result once the back part has handled
// it; a successful read first passes through S_READ, since the slot memory
// read is registered. The block takes no new request until the back part is
// through with the last one. The receiver cannot stall: results are never
// held. Configuration must be written through cfg_we, cfg_index and cfg_data
// only while no request is pending; the block does not enforce this. Reset
// clears all pointers, counts and peaks and restores the register defaults;
// slot contents stay undefined until written.
`default_nettype none
module urgent_capable_message_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [2:0]  queue_id,
  input  wire logic [63:0] write_data,
  input  wire logic [3:0]  byte_len,
  input  wire logic        urgent,
  input  wire logic        may_wait,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  output logic             done,
  output logic [2:0]       status,
  output logic [63:0]      read_data,
  output logic [3:0]       read_len,
  output logic [4:0]       peak_fill
);
  import ucmq_pkg::*;

  cmd_t       f_cmd, q_cmd;
  logic [4:0] node_count;
  logic [3:0] max_msg_bytes;
  logic       accept, pop, q_valid, q_full, back_busy, pend;

  // One request in flight at a time keeps pointer reads coherent.
  assign accept = start && !busy;
  assign busy   = q_full || q_valid || back_busy || pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept;
    end
  end

  ucmq_front u_front (
    .clk, .rst, .req_type, .queue_id, .write_data, .byte_len,
    .urgent, .may_wait, .cfg_we, .cfg_index, .cfg_data,
    .cmd(f_cmd), .node_count, .max_msg_bytes
  );

  ucmq_fifo u_fifo (
    .clk, .rst, .push(accept), .din(f_cmd), .pop(pop), .dout(q_cmd),
    .not_empty(q_valid), .full(q_full)
  );

  ucmq_back u_back (
    .clk, .rst, .cmd_valid(q_valid), .cmd(q_cmd), .node_count, .max_msg_bytes,
    .cmd_pop(pop), .busy_back(back_busy), .done, .status, .read_data,
    .read_len, .peak_fill
  );
endmodule
`default_nettype wire

// ===== verif/tb_urgent_capable_message_queue.sv =====
// Testbench for the urgent-capable message queue block.
// Depends on ucmq_pkg and urgent_capable_message_queue; a scoreboard class
// predicts every result from its own copy of the queue state.
`default_nettype none
module tb_urgent_capable_message_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import ucmq_pkg::*;

  localparam int RUN_LIMIT = 200000;

  typedef struct {
    logic        is_write;
    logic [2:0]  queue;
    logic [63:0] data;
    logic [3:0]  len;
    logic        urgent;
    logic        may_wait;
  } request_t;

  typedef struct {
    status_t     status;
    logic [63:0] data;
    logic [3:0]  len;
    logic [4:0]  peak;
  } reply_t;

  // Queue-state predictor and store of expected replies.
  class msg_queue_scoreboard;
    int unsigned active_q = 4, created = 0, nodes_reg = 16, max_len = 8;
    int unsigned head[4], tail[4], fill[4], peak[4];
    logic [63:0] payload[64];
    int unsigned stored_len[64];
    bit          written[64];
    reply_t      pending_replies[$];
    int          errors = 0;
    int          checked = 0;
    int          requests = 0;

    function void set_reg(reg_index_t idx, int unsigned value);
      case (idx)
        REG_ACTIVE:  active_q = value & 7;
        REG_CREATED: created = value & 15;
        REG_NODES:   nodes_reg = value & 31;
        default:     max_len = value & 15;
      endcase
    endfunction

    function int unsigned slot_count();
      if (nodes_reg == 0) return 1;
      if (nodes_reg > DEPTH) return DEPTH;
      return nodes_reg;
    endfunction

    function logic [63:0] keep_bytes(int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // True when a read would hit a slot that no write has filled yet.
    function bit hits_unwritten(request_t r);
      int unsigned q, s;
      q = r.queue;
      if (r.is_write || q >= active_q || q >= NUM_QUEUES || r.len == 0) return 0;
      if (!created[q] || fill[q] == 0) return 0;
      s = head[q] >= DEPTH ? DEPTH - 1 : head[q];
      return !written[q * DEPTH + s];
    endfunction

    // Predict the reply to one accepted request beat and update the state.
    function void note(request_t r);
      reply_t      e;
      int unsigned q, nodes, lim, s, n;
      q = r.queue;
      nodes = slot_count();
      lim = max_len < MSG_BYTES ? max_len : MSG_BYTES;
      e.status = ST_OK;
      e.data = '0;
      e.len = '0;
      e.peak = '0;
      requests++;
      if (q >= active_q || q >= NUM_QUEUES) begin
        e.status = ST_BAD_QUEUE;
      end else if (r.len == 0) begin
        e.status = ST_ZERO_LEN;
      end else if (!created[q]) begin
        e.status = ST_NOT_CREATED;
      end else if (r.is_write) begin
        if (r.len > lim) begin
          e.status = ST_TOO_BIG;
        end else if (fill[q] >= nodes) begin
          e.status = r.may_wait ? ST_WOULD_BLOCK : ST_EMPTY_FULL;
        end else begin
          if (r.urgent) begin
            if (head[q] == 0 || head[q] > nodes) head[q] = nodes - 1;
            else head[q] = head[q] - 1;
            s = head[q];
          end else begin
            s = tail[q];
            tail[q] = (s + 1 >= nodes) ? 0 : s + 1;
          end
          if (s >= DEPTH) s = DEPTH - 1;
          payload[q * DEPTH + s] = r.data & keep_bytes(r.len);
          stored_len[q * DEPTH + s] = r.len;
          written[q * DEPTH + s] = 1;
          fill[q]++;
          if (fill[q] > peak[q]) peak[q] = fill[q];
        end
      end else begin
        if (fill[q] == 0) begin
          e.status = r.may_wait ? ST_WOULD_BLOCK : ST_EMPTY_FULL;
        end else begin
          s = head[q] >= DEPTH ? DEPTH - 1 : head[q];
          n = r.len < stored_len[q * DEPTH + s] ? r.len : stored_len[q * DEPTH + s];
          if (n > 8) n = 8;
          e.len = 4'(n);
          e.data = payload[q * DEPTH + s] & keep_bytes(n);
          head[q] = (head[q] + 1 >= nodes) ? 0 : head[q] + 1;
          fill[q]--;
        end
      end
      if (e.status != ST_BAD_QUEUE) e.peak = 5'(peak[q]);
      pending_replies.push_back(e);
    endfunction

    // Compare one reply beat against the oldest prediction.
    function void check(reply_t got);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $error("reply with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.data !== e.data) begin
        $error("read_data: expected %h, got %h", e.data, got.data);
        errors++;
      end
      if (got.len !== e.len) begin
        $error("read_len: expected %0d, got %0d", e.len, got.len);
        errors++;
      end
      if (got.peak !== e.peak) begin
        $error("peak_fill: expected %0d, got %0d", e.peak, got.peak);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        req_type = 0;
  logic [2:0]  queue_id = 0;
  logic [63:0] write_data = 0;
  logic [3:0]  byte_len = 0;
  logic        urgent = 0;
  logic        may_wait = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [4:0]  cfg_data = 0;
  logic        done;
  logic [2:0]  status;
  logic [63:0] read_data;
  logic [3:0]  read_len;
  logic [4:0]  peak_fill;

  msg_queue_scoreboard sb = new();
  int          idle_pct = 0;
  int          settings = 0;
  int unsigned cycles = 0;

  urgent_capable_message_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .queue_id(queue_id), .write_data(write_data),
    .byte_len(byte_len), .urgent(urgent), .may_wait(may_wait),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .read_data(read_data),
    .read_len(read_len), .peak_fill(peak_fill)
  );

  always #4 clk = ~clk;

  // Run watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Reply monitor: every reply beat lasts one cycle and cannot be held.
  always @(posedge clk) begin
    reply_t got;
    if (!rst && done) begin
      got.status = status_t'(status);
      got.data = read_data;
      got.len = read_len;
      got.peak = peak_fill;
      sb.check(got);
    end
  end

  // Write all four registers, one per clock, while the block is idle.
  task automatic program_regs(int unsigned act, int unsigned crt, int unsigned nds,
                              int unsigned mx);
    reg_index_t  idx[4];
    int unsigned val[4];
    idx = '{REG_ACTIVE, REG_CREATED, REG_NODES, REG_MAXLEN};
    val = '{act, crt, nds, mx};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= 5'(val[i]);
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Let every outstanding reply drain, plus the block's longest latency.
  task automatic drain();
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Present one request beat and hold it until the block takes it.
  task automatic send(request_t r);
    start <= 1;
    req_type <= r.is_write;
    queue_id <= r.queue;
    write_data <= r.data;
    byte_len <= r.len;
    urgent <= r.urgent;
    may_wait <= r.may_wait;
    do @(posedge clk); while (busy);
    sb.note(r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic issue(logic w, logic [2:0] q, logic [63:0] d, logic [3:0] n,
                       logic u, logic mw);
    request_t r;
    r = '{w, q, d, n, u, mw};
    send(r);
  endtask

  // Mostly well-formed traffic to live queues, with some noise.
  task automatic random_phase(int count);
    request_t    r;
    int unsigned live, lim;
    for (int i = 0; i < count; i++) begin
      live = sb.active_q < NUM_QUEUES ? sb.active_q : NUM_QUEUES;
      lim = sb.max_len < MSG_BYTES ? sb.max_len : MSG_BYTES;
      r.is_write = 1'($urandom_range(1));
      r.data = {$urandom, $urandom};
      r.urgent = $urandom_range(99) < 30;
      r.may_wait = 1'($urandom_range(1));
      if (live > 0 && $urandom_range(99) < 88) r.queue = 3'($urandom_range(live - 1));
      else r.queue = 3'($urandom_range(7));
      if (lim > 0 && $urandom_range(99) < 88) r.len = 4'($urandom_range(1, lim));
      else r.len = 4'($urandom_range(15));
      if (sb.hits_unwritten(r)) r.is_write = 1;
      send(r);
    end
    start <= 0;
    @(posedge clk);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: error checks in order, full and empty, urgent wrap, truncation.
    program_regs(3, 4'b0101, 2, 8);
    issue(1, 3, '1, 1, 0, 0);
    issue(1, 7, '1, 1, 0, 0);
    issue(0, 0, '0, 0, 0, 0);
    issue(1, 1, '1, 4, 0, 0);
    issue(1, 0, '1, 9, 0, 0);
    issue(1, 0, '1, 15, 0, 1);
    issue(0, 0, '0, 8, 0, 0);
    issue(0, 0, '0, 8, 0, 1);
    issue(1, 0, '1, 8, 0, 0);
    issue(1, 0, 64'h0123_4567_89ab_cdef, 1, 1, 0);
    issue(1, 0, '1, 2, 0, 0);
    issue(1, 0, '1, 2, 1, 1);
    issue(0, 0, '0, 15, 0, 0);
    issue(0, 0, '0, 3, 0, 0);
    issue(1, 2, 64'ha5a5_5a5a_f00f_0ff0, 7, 1, 0);
    issue(1, 2, '0, 1, 0, 1);
    issue(0, 2, '0, 8, 0, 0);
    issue(0, 2, '0, 8, 0, 1);
    start <= 0;
    @(posedge clk);
    drain();
    program_regs(4, 4'b1111, 16, 0);
    issue(1, 3, '1, 1, 0, 0);
    issue(0, 3, '0, 1, 0, 0);
    start <= 0;
    @(posedge clk);
    drain();

    // Random phases over several register settings and sender gap rates.
    program_regs(4, 4'b1111, 16, 8);
    idle_pct = 0;
    random_phase(150);
    program_regs(7, 4'b1110, 0, 15);
    idle_pct = 84;
    random_phase(100);
    program_regs(1, 4'b0001, 31, 3);
    idle_pct = 21;
    random_phase(100);
    program_regs(4, 4'b1111, 5, 0);
    idle_pct = 0;
    random_phase(30);
    program_regs(4, 4'b1111, 3, 8);
    idle_pct = 84;
    random_phase(120);

    repeat (10) @(posedge clk);
    if (sb.pending_replies.size() != 0) begin
      $error("%0d expected replies never arrived", sb.pending_replies.size());
      sb.errors++;
    end
    $display("Ran %0d requests under %0d register settings; %0d replies checked.",
             sb.requests, settings, sb.checked);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
